FILE: sv/spline_path_sampler_core_defines.svh
// Assertion macros shared by the checker files of the spline path sampler.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef SPLINE_PATH_SAMPLER_CORE_DEFINES_SVH
`define SPLINE_PATH_SAMPLER_CORE_DEFINES_SVH

// Consequent checked in the cycle after the antecedent, ignored while in reset.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent, ignored while in reset.
`define SPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent, also during reset.
`define SPS_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sps_pkg.sv
// Shared types and constants of the spline path sampler.
// Used by the controller, the datapath, the axis lanes and the top level.
package sps_pkg;

    // Width of the step size register, Q1.16 style increment of T.
    localparam int STEP_W = 17;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd16384;

    // A run holds at most 2^CNT_W samples.
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] LAST_COUNT = '1;

    // Stages of the evaluation pyramid, run in this order.
    typedef enum logic [2:0] {
        STG_A0,
        STG_A1,
        STG_A2,
        STG_B0,
        STG_B1,
        STG_C
    } stage_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   fill;     // fill the window with three copies of the point
        logic   load;     // latch the new point and start a run at T = 1
        logic   mul;      // form both products of the current stage
        logic   fin;      // add, shift and store the current stage result
        logic   emit;     // move the finished sample into the output register
        logic   advance;  // step T to the next sample
        logic   shift;    // shift the window after the last sample
        stage_t stage;
    } sps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;       // the sample now finished closes the run
        logic out_free;   // the output register can take a sample this cycle
    } sps_status_t;

endpackage

FILE: sv/sps_lane.sv
// One coordinate axis of the spline path sampler: window, pyramid registers
// and a two-multiplier blend unit. Depends on sps_pkg.
module sps_lane import sps_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          aclk,
    input  sps_cmd_t                      cmd,
    input  logic signed [COORD_WIDTH-1:0] point,
    input  logic signed [FRAC_BITS+2:0]   coef0,
    input  logic signed [FRAC_BITS+2:0]   coef1,
    output logic signed [COORD_WIDTH-1:0] sample
);

    // Pyramid values need four bits over a coordinate.
    localparam int VW  = COORD_WIDTH + 4;
    localparam int CFW = FRAC_BITS + 3;
    localparam int PW  = VW + CFW;
    localparam int SW  = PW + 1;

    logic signed [COORD_WIDTH-1:0] w0_reg, w1_reg, w2_reg, p3_reg;
    logic signed [COORD_WIDTH-1:0] w0_next, w1_next, w2_next, p3_next;
    logic signed [VW-1:0] a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, c_reg;
    logic signed [VW-1:0] a0_next, a1_next, a2_next, b0_next, b1_next, c_next;
    logic signed [PW-1:0] prod0_reg, prod1_reg, prod0_next, prod1_next;
    logic signed [VW-1:0] v0, v1, res;
    logic signed [SW-1:0] sum;
    logic [VW-COORD_WIDTH:0] c_top;

    always_comb begin
        case (cmd.stage)
            STG_A0: begin
                v0 = VW'(w0_reg);
                v1 = VW'(w1_reg);
            end
            STG_A1: begin
                v0 = VW'(w1_reg);
                v1 = VW'(w2_reg);
            end
            STG_A2: begin
                v0 = VW'(w2_reg);
                v1 = VW'(p3_reg);
            end
            STG_B0: begin
                v0 = a0_reg;
                v1 = a1_reg;
            end
            STG_B1: begin
                v0 = a1_reg;
                v1 = a2_reg;
            end
            default: begin
                v0 = b0_reg;
                v1 = b1_reg;
            end
        endcase
    end

    assign prod0_next = cmd.mul ? PW'(v0) * PW'(coef0) : prod0_reg;
    assign prod1_next = cmd.mul ? PW'(v1) * PW'(coef1) : prod1_reg;

    // The first row divides by one unit of T, the later rows by two.
    assign sum = SW'(prod0_reg) + SW'(prod1_reg);
    assign res = (cmd.stage == STG_A0 || cmd.stage == STG_A1 || cmd.stage == STG_A2)
               ? VW'(sum >>> FRAC_BITS) : VW'(sum >>> (FRAC_BITS + 1));

    assign a0_next = (cmd.fin && cmd.stage == STG_A0) ? res : a0_reg;
    assign a1_next = (cmd.fin && cmd.stage == STG_A1) ? res : a1_reg;
    assign a2_next = (cmd.fin && cmd.stage == STG_A2) ? res : a2_reg;
    assign b0_next = (cmd.fin && cmd.stage == STG_B0) ? res : b0_reg;
    assign b1_next = (cmd.fin && cmd.stage == STG_B1) ? res : b1_reg;
    assign c_next  = (cmd.fin && cmd.stage == STG_C)  ? res : c_reg;

    always_comb begin
        w0_next = w0_reg;
        w1_next = w1_reg;
        w2_next = w2_reg;
        if (cmd.fill) begin
            w0_next = point;
            w1_next = point;
            w2_next = point;
        end else if (cmd.shift) begin
            w0_next = w1_reg;
            w1_next = w2_reg;
            w2_next = p3_reg;
        end
    end

    assign p3_next = cmd.load ? point : p3_reg;

    always_ff @(posedge aclk) begin
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        p3_reg    <= p3_next;
        prod0_reg <= prod0_next;
        prod1_reg <= prod1_next;
        a0_reg    <= a0_next;
        a1_reg    <= a1_next;
        a2_reg    <= a2_next;
        b0_reg    <= b0_next;
        b1_reg    <= b1_next;
        c_reg     <= c_next;
    end

    // Saturate when the bits above the coordinate do not all copy its sign.
    assign c_top = c_reg[VW-1:COORD_WIDTH-1];
    always_comb begin
        if (&c_top || ~|c_top) begin
            sample = c_reg[COORD_WIDTH-1:0];
        end else if (c_reg[VW-1]) begin
            sample = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            sample = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

endmodule

FILE: sv/sps_datapath.sv
// Datapath of the spline path sampler: step register, T accumulator,
// coefficients, three axis lanes and the output register.
// Depends on sps_pkg and sps_lane.
module sps_datapath import sps_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [STEP_W-1:0]                 cfg_wdata,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     point_z,
    input  sps_cmd_t                          cmd,
    output sps_status_t                       status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                              m_tlast
);

    localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int CFW   = FRAC_BITS + 3;
    localparam int TW    = ((FRAC_BITS + 1 > STEP_W) ? FRAC_BITS + 1 : STEP_W) + 1;
    localparam logic [TW-1:0] ONE_T    = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] TWO_T    = TW'(2) << FRAC_BITS;
    localparam logic [TW-1:0] MIN_STEP = TW'(1) << (FRAC_BITS - CNT_W);
    localparam logic signed [CFW-1:0] S1 = CFW'(1) << FRAC_BITS;
    localparam logic signed [CFW-1:0] S2 = CFW'(2) << FRAC_BITS;
    localparam logic signed [CFW-1:0] S3 = CFW'(3) << FRAC_BITS;

    logic [STEP_W-1:0]  step_reg, step_next;
    logic [TW-1:0]      t_reg, t_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_last_reg, m_last_next;
    logic [3*COORD_WIDTH-1:0] m_data_reg, m_data_next;
    logic [TW-1:0]      step_ext, step_eff, t_step;
    logic signed [CFW-1:0] u, coef0, coef1;
    logic signed [COORD_WIDTH-1:0] sample_x, sample_y, sample_z;

    // Steps below 1/64 are raised so a run never exceeds 64 samples.
    assign step_ext = TW'(step_reg);
    assign step_eff = (step_ext < MIN_STEP) ? MIN_STEP : step_ext;
    assign t_step   = t_reg + step_eff;

    assign status.last     = (t_step >= TWO_T) || (count_reg == LAST_COUNT);
    assign status.out_free = !m_valid_reg || m_tready;

    // T stays below two during a run, so its low bits carry it exactly.
    assign u = signed'({1'b0, t_reg[FRAC_BITS+1:0]});

    always_comb begin
        case (cmd.stage)
            STG_A0: begin
                coef0 = S1 - u;
                coef1 = u;
            end
            STG_A1: begin
                coef0 = S2 - u;
                coef1 = u - S1;
            end
            STG_A2: begin
                coef0 = S3 - u;
                coef1 = u - S2;
            end
            STG_B0: begin
                coef0 = S2 - u;
                coef1 = u;
            end
            STG_B1: begin
                coef0 = S3 - u;
                coef1 = u - S1;
            end
            default: begin
                coef0 = S2 - u;
                coef1 = u;
            end
        endcase
    end

    sps_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
        .aclk   (aclk),
        .cmd    (cmd),
        .point  (point_x),
        .coef0  (coef0),
        .coef1  (coef1),
        .sample (sample_x)
    );

    sps_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
        .aclk   (aclk),
        .cmd    (cmd),
        .point  (point_y),
        .coef0  (coef0),
        .coef1  (coef1),
        .sample (sample_y)
    );

    sps_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_z (
        .aclk   (aclk),
        .cmd    (cmd),
        .point  (point_z),
        .coef0  (coef0),
        .coef1  (coef1),
        .sample (sample_z)
    );

    assign step_next = cfg_we ? cfg_wdata : step_reg;

    always_comb begin
        t_next     = t_reg;
        count_next = count_reg;
        if (cmd.load) begin
            t_next     = ONE_T;
            count_next = '0;
        end else if (cmd.advance) begin
            t_next     = t_step;
            count_next = count_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_last_next  = status.last;
            m_data_next  = {sample_z, sample_y, sample_x};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        count_reg  <= count_next;
        m_last_reg <= m_last_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

endmodule

FILE: sv/sps_ctrl.sv
// Controller of the spline path sampler: accepts waypoints and sequences the
// pyramid stages and the sample hand-off. Depends on sps_pkg.
module sps_ctrl import sps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        path_start,
    output logic        s_tready,
    input  sps_status_t status,
    output sps_cmd_t    cmd
);

    state_t state_reg, state_next;
    stage_t stage_reg, stage_next;
    logic   have_reg, have_next;
    logic   accept;
    logic   restart;

    assign accept  = s_tvalid && (state_reg == ST_IDLE);
    assign restart = path_start || !have_reg;

    always_comb begin
        state_next = state_reg;
        stage_next = stage_reg;
        have_next  = have_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    have_next = 1'b1;
                    if (!restart) begin
                        state_next = ST_MUL;
                        stage_next = STG_A0;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                case (stage_reg)
                    STG_A0:  stage_next = STG_A1;
                    STG_A1:  stage_next = STG_A2;
                    STG_A2:  stage_next = STG_B0;
                    STG_B0:  stage_next = STG_B1;
                    STG_B1:  stage_next = STG_C;
                    default: stage_next = STG_C;
                endcase
                state_next = (stage_reg == STG_C) ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = status.last ? ST_IDLE : ST_MUL;
                    stage_next = STG_A0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        cmd         = '0;
        cmd.stage   = stage_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.fill = accept && restart;
                cmd.load = accept && !restart;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit    = status.out_free;
                cmd.advance = status.out_free && !status.last;
                cmd.shift   = status.out_free && status.last;
            end
            default: begin
                cmd.stage = stage_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stage_reg <= STG_A0;
            have_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            stage_reg <= stage_next;
            have_reg  <= have_next;
        end
    end

endmodule

FILE: sv/spline_path_sampler_core.sv
// Top level of the spline path sampler: waypoint stream in, spline samples out.
// Depends on sps_pkg, sps_ctrl and sps_datapath.
//
// The block samples a uniform Catmull-Rom style spline through a stream of 3D
// waypoints in signed fixed point (FRAC_BITS fraction bits). A waypoint with
// the path start flag set in s_tuser, or the first one after reset, only
// primes the window and produces no item. Every other waypoint produces one
// sample item for each T = 1, 1+step, ... below 2, at most 64 of them, with
// m_tlast on the last one. A waypoint is taken while the block is idle; one
// that closes a segment then keeps the input closed until its last sample
// is handed off, and longer while the output side stalls. For each sample the
// per-axis blend unit runs the six stages of the evaluation pyramid
// in turn, each a products step and then a sum and shift step, and then
// hands the sample to the output register. The output register
// parts the two sides: the input reopens while the last sample still waits
// to be taken. The step size register, cfg_wdata, is written whenever
// cfg_we is high and should only change while the block is idle. Samples
// are saturated to the coordinate range.
module spline_path_sampler_core import sps_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Step size of T per sample, FRAC_BITS fraction bits.
    input  logic                                cfg_we,
    input  logic [STEP_W-1:0]                   cfg_wdata,
    // Fields from bit 0 up: point_x, point_y, point_z, zero fill.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    // Fields from bit 0 up: path_start.
    input  logic [0:0]                          s_tuser,
    // Fields from bit 0 up: sample_x, sample_y, sample_z, zero fill.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // The last sample caused by one waypoint.
    output logic                                m_tlast
);

    // Width of both data buses, used by the bound checker.
    localparam int OUT_DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;

    sps_cmd_t    cmd;
    sps_status_t status;
    logic signed [COORD_WIDTH-1:0] point_x, point_y, point_z;

    assign point_x = s_tdata[COORD_WIDTH-1:0];
    assign point_y = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign point_z = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

    // The controller owns the input handshake and the run sequence.
    sps_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .path_start (s_tuser[0]),
        .s_tready   (s_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the windows, the arithmetic and the output register.
    sps_datapath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: sv/sps_checker.sv
// Port-level checker for the spline path sampler and its bind statement.
// Depends on spline_path_sampler_core_defines.svh.
`include "spline_path_sampler_core_defines.svh"

module sps_checker #(
    parameter int DATA_W = 96
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [0:0]        s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast
);

    // Reset empties the output register.
    `SPS_ASSERT_RESET(a_reset_clears_out, !aresetn, !m_tvalid, "output valid after reset")

    // A waiting item is neither dropped nor changed.
    `SPS_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "output item dropped")
    `SPS_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tlast), "stalled output item changed")

    // A path start item only primes the window, so the input stays open.
    `SPS_ASSERT_NEXT(a_start_stays_open, s_tvalid && s_tready && s_tuser[0], s_tready,
        "input closed after a path start item")

    // While a run is still open the block takes no new waypoint.
    `SPS_ASSERT_SAME(a_run_blocks_input, m_tvalid && m_tready && !m_tlast, !s_tready,
        "waypoint taken in the middle of a run")

endmodule

bind spline_path_sampler_core sps_checker #(.DATA_W(OUT_DATA_W)) u_sps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: bench/spline_path_sampler_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for spline_path_sampler_core: streams waypoints, predicts every
// spline sample with its own fixed point pyramid and compares the sample stream field by field.
// Depends on sps_pkg and the spline_path_sampler_core RTL.
module spline_path_sampler_core_tb import sps_pkg::*; ();

    localparam int COORD_W       = 32;
    localparam int FRAC_W        = 16;
    localparam int DATA_W        = ((3*COORD_W+7)/8)*8;
    localparam longint ONE_T     = longint'(1) <<< FRAC_W;
    localparam longint MIN_STEP  = ONE_T >>> 6;
    localparam int MAX_RUN       = 64;
    localparam longint SAT_HI    = (longint'(1) <<< (COORD_W-1)) - 1;
    localparam longint SAT_LO    = -SAT_HI - 1;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASE_POINTS  = 44;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } sample_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    // Predictor state: the sample window per axis and the step register copy.
    coord_t            win[3][3];
    logic              have_point;
    logic [STEP_W-1:0] step_reg;
    sample_t           sample_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int errors         = 0;
    int points_sent    = 0;
    int samples_seen   = 0;
    int steps_written  = 0;

    spline_path_sampler_core #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS  (FRAC_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // One axis of the pyramid. Every stage is exact in 64 bits and floors by an arithmetic shift.
    function automatic coord_t spline_axis(coord_t w0, coord_t w1, coord_t w2, coord_t p3,
                                           longint u);
        longint s, a0, a1, a2, b0, b1, c;
        s  = ONE_T;
        a0 = ((s - u) * longint'(w0) + u * longint'(w1)) >>> FRAC_W;
        a1 = ((2*s - u) * longint'(w1) + (u - s) * longint'(w2)) >>> FRAC_W;
        a2 = ((3*s - u) * longint'(w2) + (u - 2*s) * longint'(p3)) >>> FRAC_W;
        b0 = ((2*s - u) * a0 + u * a1) >>> (FRAC_W + 1);
        b1 = ((3*s - u) * a1 + (u - s) * a2) >>> (FRAC_W + 1);
        c  = ((2*s - u) * b0 + u * b1) >>> (FRAC_W + 1);
        if (c > SAT_HI) c = SAT_HI;
        if (c < SAT_LO) c = SAT_LO;
        return coord_t'(c);
    endfunction

    // Queues the samples one accepted waypoint produces and updates the window.
    task automatic predict_samples(input coord_t px, input coord_t py, input coord_t pz,
                                   input logic start);
        coord_t  pt[3];
        longint  u, step;
        int      n;
        sample_t smp;
        pt = '{px, py, pz};
        if (start || !have_point) begin
            for (int a = 0; a < 3; a++) win[a] = '{pt[a], pt[a], pt[a]};
            have_point = 1'b1;
            return;
        end
        step = longint'(step_reg);
        if (step < MIN_STEP) step = MIN_STEP;
        u = ONE_T;
        n = 0;
        while (u < 2*ONE_T && n < MAX_RUN) begin
            smp.x    = spline_axis(win[0][0], win[0][1], win[0][2], pt[0], u);
            smp.y    = spline_axis(win[1][0], win[1][1], win[1][2], pt[1], u);
            smp.z    = spline_axis(win[2][0], win[2][1], win[2][2], pt[2], u);
            smp.last = (u + step >= 2*ONE_T) || (n + 1 == MAX_RUN);
            sample_q.insert(sample_q.size(), smp);
            n++;
            u += step;
        end
        for (int a = 0; a < 3; a++) win[a] = '{win[a][1], win[a][2], pt[a]};
    endtask

    // Offers one waypoint after a random idle gap and waits until it is taken.
    task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                              input logic start);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({pz, py, px});
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        predict_samples(px, py, pz, start);
        points_sent++;
    endtask

    // Closes the input and waits until every predicted sample has come out and the block rests.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sample_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_step(input logic [STEP_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        step_reg = value;
        steps_written++;
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(6))
            0: return C_MAX;
            1: return C_MIN;
            2: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            3: return C_MAX - coord_t'($urandom_range(0, 1 << 18));
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Mostly ordinary steps, with the clamped small and the single-sample large ranges mixed in.
    function automatic logic [STEP_W-1:0] rand_step();
        case ($urandom_range(9))
            0: return STEP_W'($urandom_range(0, 1023));
            1: return STEP_W'($urandom_range(65536, 131071));
            default: return STEP_W'($urandom_range(1024, 65536));
        endcase
    endfunction

    task automatic send_random(input logic start);
        send_point(rand_coord(), rand_coord(), rand_coord(), start);
    endtask

    // The reset step size is used without a write; the first waypoint after reset only
    // primes the window even though its path start flag is clear.
    task automatic test_first_point();
        send_point('0, '0, '0, 1'b0);
        send_point(C_MAX, C_MIN, coord_t'(32'sh0001_0000), 1'b0);
        send_point(C_MIN, C_MAX, -1, 1'b0);
        send_point(coord_t'(12345), coord_t'(-678910), '0, 1'b1);
        send_point(-1, coord_t'(1), coord_t'(32'sh7fff_0000), 1'b0);
    endtask

    // A segment between two equal extremes with steep neighbors bulges past the coordinate
    // range, so x saturates high and y saturates low.
    task automatic test_overshoot();
        send_point(C_MIN, C_MAX, coord_t'(7), 1'b1);
        send_point(C_MAX, C_MIN, coord_t'(-7), 1'b0);
        send_point(C_MAX, C_MIN, coord_t'(32'sh0000_8000), 1'b0);
        send_point(C_MIN, C_MAX, coord_t'(-32'sh0000_8000), 1'b0);
    endtask

    // Zero and just below 1/64 are clamped to 64 samples; one and above give a single sample.
    task automatic test_step_extremes();
        logic [STEP_W-1:0] steps[6];
        steps = '{17'd0, 17'd1023, 17'd1024, 17'd65535, 17'd65536, 17'd131071};
        foreach (steps[i]) begin
            set_step(steps[i]);
            send_random(1'b1);
            send_random(1'b0);
        end
    endtask

    // The output side holds off long enough for the block to fill and close its input
    // while waypoints keep arriving.
    task automatic test_output_hold();
        set_step(17'd4096);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        send_random(1'b1);
        repeat (5) send_random(1'b0);
        wait_drained();
    endtask

    // Random paths under four idle patterns. Most traffic is well-formed paths; the rest
    // continues without a start, restarts twice in a row or changes the step size.
    task automatic test_random_traffic();
        int send_pct[4];
        int recv_pct[4];
        int sent;
        int kind;
        send_pct = '{0, 71, 0, 38};
        recv_pct = '{0, 0, 71, 38};
        for (int p = 0; p < 4; p++) begin
            set_step(rand_step());
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            sent = 0;
            while (sent < PHASE_POINTS) begin
                kind = $urandom_range(9);
                if (kind <= 6) begin
                    send_random(1'b1);
                    sent++;
                    repeat ($urandom_range(1, 8)) begin
                        send_random(1'b0);
                        sent++;
                    end
                end else if (kind == 7) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_random(1'($urandom_range(1)));
                        sent++;
                    end
                end else if (kind == 8) begin
                    send_random(1'b1);
                    send_random(1'b1);
                    send_random(1'b0);
                    sent += 3;
                end else begin
                    set_step(rand_step());
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Output ready: a requested hold first, otherwise random stalls at the phase's rate.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            samples_seen++;
            if (sample_q.size() == 0) begin
                $error("sample with none expected: x=%0d y=%0d z=%0d last=%0b",
                       coord_t'(m_tdata[COORD_W-1:0]), coord_t'(m_tdata[2*COORD_W-1:COORD_W]),
                       coord_t'(m_tdata[3*COORD_W-1:2*COORD_W]), m_tlast);
                errors++;
            end else begin
                want = sample_q.pop_front();
                check_field("sample_x", want.x, coord_t'(m_tdata[COORD_W-1:0]));
                check_field("sample_y", want.y, coord_t'(m_tdata[2*COORD_W-1:COORD_W]));
                check_field("sample_z", want.z, coord_t'(m_tdata[3*COORD_W-1:2*COORD_W]));
                check_field("run_end", want.last, m_tlast);
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = STEP_RESET;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        for (int a = 0; a < 3; a++) win[a] = '{'0, '0, '0};
        have_point = 1'b0;
        step_reg   = STEP_RESET;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_first_point();
        test_overshoot();
        test_step_extremes();
        test_output_hold();
        test_random_traffic();
        wait_drained();

        $display("Run covered %0d waypoints and %0d samples over %0d step settings,",
                 points_sent, samples_seen, steps_written + 1);
        $display("four idle patterns, a %0d-cycle output hold and saturating segments.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
